/* sv/pdrv_pkg.sv */
package pdrv_pkg;

  // Position and error formats, Q.4 degrees.
  localparam int PosW   = 24;
  localparam int ErrW   = PosW + 1;
  localparam int DiffW  = PosW + 2;

  // Unsigned Q4.12 gains, widened by one sign bit for signed products.
  localparam int GainW  = 16;
  localparam int PProdW = GainW + 1 + ErrW;
  localparam int DProdW = GainW + 1 + DiffW;

  // Band registers and the speed limit.
  localparam int BandW  = 23;
  localparam int SpdLimW = 15;
  localparam int SpeedOutW = 16;

  // Integral accumulator, Q.16 percent.
  localparam int IntegW = 40;
  localparam int IsumW  = ((IntegW > PProdW) ? IntegW : PProdW) + 1;

  // Sum of P, I and D, and the Q29.8 speed after the shift by eight.
  localparam int TotW   = ((DProdW > IntegW) ? DProdW : IntegW) + 2;
  localparam int FracShift = 8;
  localparam int SpeedW = TotW - FracShift;

  // Width used to compare the absolute error with the bands.
  localparam int CmpW   = (ErrW > BandW) ? ErrW : BandW;

  // Configuration port.
  localparam int CfgW   = (PosW > BandW) ? PosW : BandW;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGainP        = 3'd0,
    CfgGainI        = 3'd1,
    CfgGainD        = 3'd2,
    CfgIntegralZone = 3'd3,
    CfgMaxSpeed     = 3'd4,
    CfgTargetPos    = 3'd5,
    CfgSettleError  = 3'd6
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [GainW-1:0]   GainPRst   = 16'd1516;
  localparam logic [GainW-1:0]   GainIRst   = 16'd0;
  localparam logic [GainW-1:0]   GainDRst   = 16'd1229;
  localparam logic [BandW-1:0]   IzoneRst   = 23'd800;
  localparam logic [SpdLimW-1:0] MaxSpdRst  = 15'd25600;
  localparam logic [BandW-1:0]   SettleRst  = 23'd3;

  // One percent in Q8.8.
  localparam int OnePercent = 256;

endpackage

/* sv/position_pid_drive.sv */
// Position PID controller with an integral zone. Each input beat carries a
// measured position (Q.4 degrees) and a restart flag; each produces exactly one
// output beat with a signed Q8.8 speed command and a move-done flag. The block
// is a five-register pipeline (input, error, products, integral, output) and
// accepts one beat per clock unless out_stall_i holds the pipeline back. The
// integral and previous-error state are updated in pipeline order, so
// back-to-back beats see the state left by the beat before them. A restart
// clears both before the sample is used. Configuration registers are to be
// written through cfg_we_i only while the pipeline is empty; the block itself
// does not enforce this. A write to an index above six is ignored.
module position_pid_drive (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pdrv_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [pdrv_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pdrv_pkg::PosW-1:0]     measured_position_i,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pdrv_pkg::SpeedOutW-1:0] drive_speed_o,
  output logic                                 move_done_o
);

  // Configuration registers.
  logic [pdrv_pkg::GainW-1:0]        gain_p_q, gain_i_q, gain_d_q;
  logic [pdrv_pkg::BandW-1:0]        izone_q, settle_q;
  logic [pdrv_pkg::SpdLimW-1:0]      max_spd_q;
  logic signed [pdrv_pkg::PosW-1:0]  target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= pdrv_pkg::GainPRst;
      gain_i_q  <= pdrv_pkg::GainIRst;
      gain_d_q  <= pdrv_pkg::GainDRst;
      izone_q   <= pdrv_pkg::IzoneRst;
      max_spd_q <= pdrv_pkg::MaxSpdRst;
      target_q  <= '0;
      settle_q  <= pdrv_pkg::SettleRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pdrv_pkg::CfgGainP:        gain_p_q  <= cfg_data_i[pdrv_pkg::GainW-1:0];
        pdrv_pkg::CfgGainI:        gain_i_q  <= cfg_data_i[pdrv_pkg::GainW-1:0];
        pdrv_pkg::CfgGainD:        gain_d_q  <= cfg_data_i[pdrv_pkg::GainW-1:0];
        pdrv_pkg::CfgIntegralZone: izone_q   <= cfg_data_i[pdrv_pkg::BandW-1:0];
        pdrv_pkg::CfgMaxSpeed:     max_spd_q <= cfg_data_i[pdrv_pkg::SpdLimW-1:0];
        pdrv_pkg::CfgTargetPos:    target_q  <= $signed(cfg_data_i[pdrv_pkg::PosW-1:0]);
        pdrv_pkg::CfgSettleError:  settle_q  <= cfg_data_i[pdrv_pkg::BandW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage moves when it is empty or the next stage moves.
  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
  logic adv_a, adv_b, adv_c, adv_d, adv_e;

  assign adv_e = !e_v_q || !out_stall_i;
  assign adv_d = !d_v_q || adv_e;
  assign adv_c = !c_v_q || adv_d;
  assign adv_b = !b_v_q || adv_c;
  assign adv_a = !a_v_q || adv_b;
  assign in_stall_o = !adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      if (adv_a) a_v_q <= in_valid_i;
      if (adv_b) b_v_q <= a_v_q;
      if (adv_c) c_v_q <= b_v_q;
      if (adv_d) d_v_q <= c_v_q;
      if (adv_e) e_v_q <= d_v_q;
    end
  end

  // Stage A: input register.
  logic signed [pdrv_pkg::PosW-1:0] meas_a_q;
  logic                             rst_a_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv_a) begin
      meas_a_q <= measured_position_i;
      rst_a_q  <= restart_i;
    end
  end

  // Stage B: error, band checks and change in error.
  logic signed [pdrv_pkg::ErrW-1:0]  err_a, prev_eff, prev_err_q;
  logic [pdrv_pkg::ErrW-1:0]         aerr_a;
  logic [pdrv_pkg::CmpW-1:0]         aerr_cmp;
  logic signed [pdrv_pkg::DiffW-1:0] diff_a;
  logic                              zone_a, settle_a;

  assign err_a    = pdrv_pkg::ErrW'(target_q) - pdrv_pkg::ErrW'(meas_a_q);
  assign aerr_a   = err_a[pdrv_pkg::ErrW-1] ? pdrv_pkg::ErrW'(-err_a)
                                            : pdrv_pkg::ErrW'(err_a);
  assign aerr_cmp = pdrv_pkg::CmpW'(aerr_a);
  assign zone_a   = aerr_cmp < pdrv_pkg::CmpW'(izone_q);
  assign settle_a = aerr_cmp < pdrv_pkg::CmpW'(settle_q);
  assign prev_eff = rst_a_q ? '0 : prev_err_q;
  assign diff_a   = pdrv_pkg::DiffW'(err_a) - pdrv_pkg::DiffW'(prev_eff);

  logic signed [pdrv_pkg::ErrW-1:0]  err_b_q;
  logic signed [pdrv_pkg::DiffW-1:0] diff_b_q;
  logic                              zone_b_q, settle_b_q, rst_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
    end else if (a_v_q && adv_b) begin
      prev_err_q <= err_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_v_q && adv_b) begin
      err_b_q    <= err_a;
      diff_b_q   <= diff_a;
      zone_b_q   <= zone_a;
      settle_b_q <= settle_a;
      rst_b_q    <= rst_a_q;
    end
  end

  // Stage C: gain products.
  logic signed [pdrv_pkg::PProdW-1:0] p_b, ip_b;
  logic signed [pdrv_pkg::DProdW-1:0] d_b;

  assign p_b  = $signed({1'b0, gain_p_q}) * err_b_q;
  assign ip_b = $signed({1'b0, gain_i_q}) * err_b_q;
  assign d_b  = $signed({1'b0, gain_d_q}) * diff_b_q;

  logic signed [pdrv_pkg::PProdW-1:0] p_c_q, ip_c_q;
  logic signed [pdrv_pkg::DProdW-1:0] d_c_q;
  logic                               zone_c_q, settle_c_q, rst_c_q;

  always_ff @(posedge clk_i) begin
    if (b_v_q && adv_c) begin
      p_c_q      <= p_b;
      ip_c_q     <= ip_b;
      d_c_q      <= d_b;
      zone_c_q   <= zone_b_q;
      settle_c_q <= settle_b_q;
      rst_c_q    <= rst_b_q;
    end
  end

  // Stage D: saturating integral update inside the zone.
  localparam logic signed [pdrv_pkg::IntegW-1:0] IntegMax =
    {1'b0, {(pdrv_pkg::IntegW-1){1'b1}}};
  localparam logic signed [pdrv_pkg::IntegW-1:0] IntegMin =
    {1'b1, {(pdrv_pkg::IntegW-1){1'b0}}};

  logic signed [pdrv_pkg::IntegW-1:0] integ_q, integ_eff, integ_new;
  logic signed [pdrv_pkg::IsumW-1:0]  isum;

  assign integ_eff = rst_c_q ? '0 : integ_q;
  assign isum = pdrv_pkg::IsumW'(integ_eff) + pdrv_pkg::IsumW'(ip_c_q);

  always_comb begin
    if (!zone_c_q) begin
      integ_new = integ_eff;
    end else if (isum > pdrv_pkg::IsumW'(IntegMax)) begin
      integ_new = IntegMax;
    end else if (isum < pdrv_pkg::IsumW'(IntegMin)) begin
      integ_new = IntegMin;
    end else begin
      integ_new = isum[pdrv_pkg::IntegW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (c_v_q && adv_d) begin
      integ_q <= integ_new;
    end
  end

  logic signed [pdrv_pkg::PProdW-1:0] p_d_q;
  logic signed [pdrv_pkg::DProdW-1:0] d_d_q;
  logic signed [pdrv_pkg::IntegW-1:0] integ_d_q;
  logic                               settle_d_q;

  always_ff @(posedge clk_i) begin
    if (c_v_q && adv_d) begin
      p_d_q      <= p_c_q;
      d_d_q      <= d_c_q;
      integ_d_q  <= integ_new;
      settle_d_q <= settle_c_q;
    end
  end

  // Stage E: sum, Q.16 to Q8.8, speed limit and settle band.
  logic signed [pdrv_pkg::TotW-1:0]       total;
  logic signed [pdrv_pkg::SpeedW-1:0]     speed, lim;
  logic signed [pdrv_pkg::SpeedOutW-1:0]  speed_out;
  logic                                   done;

  assign total = pdrv_pkg::TotW'(p_d_q) + pdrv_pkg::TotW'(integ_d_q)
               + pdrv_pkg::TotW'(d_d_q);
  assign speed = total[pdrv_pkg::TotW-1:pdrv_pkg::FracShift];
  assign lim   = pdrv_pkg::SpeedW'({1'b0, max_spd_q});

  always_comb begin
    if (settle_d_q) begin
      speed_out = '0;
    end else if (speed > lim) begin
      speed_out = lim[pdrv_pkg::SpeedOutW-1:0];
    end else if (speed < -lim) begin
      speed_out = pdrv_pkg::SpeedOutW'(-lim);
    end else begin
      speed_out = speed[pdrv_pkg::SpeedOutW-1:0];
    end
  end

  assign done = (speed_out < pdrv_pkg::SpeedOutW'(pdrv_pkg::OnePercent)) &&
                (speed_out > -pdrv_pkg::SpeedOutW'(pdrv_pkg::OnePercent));

  logic signed [pdrv_pkg::SpeedOutW-1:0] speed_e_q;
  logic                                  done_e_q;

  always_ff @(posedge clk_i) begin
    if (d_v_q && adv_e) begin
      speed_e_q <= speed_out;
      done_e_q  <= done;
    end
  end

  assign out_valid_o   = e_v_q;
  assign drive_speed_o = speed_e_q;
  assign move_done_o   = done_e_q;

endmodule
